>>> hdl/qoi_pkg.sv
// Shared types and constants for the QOI RGB pixel encoder.
package qoi_pkg;

  localparam int unsigned IdxDepth = 64;
  localparam int unsigned SlotW    = $clog2(IdxDepth);
  localparam int unsigned RgbW     = 24;
  localparam int unsigned RunW     = 6;
  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  // Alpha is fixed at 255, so its hash term is a constant bias.
  localparam logic [SlotW-1:0] IdxBias  = SlotW'((11 * 255) % IdxDepth);
  localparam logic [RunW-1:0]  RunLimit = RunW'(62);

  localparam logic [1:0] TagIndex = 2'b00;
  localparam logic [1:0] TagDiff  = 2'b01;
  localparam logic [1:0] TagRun   = 2'b11;
  localparam logic [7:0] TagRgb   = 8'hFE;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       final_pixel;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } chunk_t;

  // Chunk bytes of one pixel, byte 0 goes out first.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
  } burst_t;

endpackage

>>> hdl/qoi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module qoi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/qoi_chunk.sv
// Chunk selection for one pixel: run, index, diff or full RGB.
module qoi_chunk
  import qoi_pkg::*;
(
  input  pix_t             pix_i,
  input  logic [RgbW-1:0]  prev_i,
  input  logic [RunW-1:0]  run_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic             idx_hit_i,
  output burst_t           burst_o,
  output logic [RunW-1:0]  run_o,
  output logic             idx_we_o
);

  logic [RgbW-1:0]  px;
  logic             same;
  logic [RunW-1:0]  run_inc;
  logic [7:0]       dr, dg, db;
  logic             diff_ok;
  logic [3:0][7:0]  body;
  logic [2:0]       body_cnt;
  logic             pend;

  assign px      = {pix_i.red, pix_i.green, pix_i.blue};
  assign same    = (px == prev_i);
  assign run_inc = run_i + RunW'(1);

  // Deltas biased by two; in range when the biased value is below four.
  assign dr = pix_i.red   - prev_i[23:16] + 8'd2;
  assign dg = pix_i.green - prev_i[15:8]  + 8'd2;
  assign db = pix_i.blue  - prev_i[7:0]   + 8'd2;
  assign diff_ok = (dr[7:2] == '0) && (dg[7:2] == '0) && (db[7:2] == '0);

  always_comb begin
    body     = '0;
    body_cnt = '0;
    if (idx_hit_i) begin
      body[0]  = {TagIndex, slot_i};
      body_cnt = 3'd1;
    end else if (diff_ok) begin
      body[0]  = {TagDiff, dr[1:0], dg[1:0], db[1:0]};
      body_cnt = 3'd1;
    end else begin
      body[0]  = TagRgb;
      body[1]  = pix_i.red;
      body[2]  = pix_i.green;
      body[3]  = pix_i.blue;
      body_cnt = 3'd4;
    end
  end

  assign pend = (run_i != '0);

  always_comb begin
    burst_o  = '0;
    run_o    = '0;
    idx_we_o = 1'b0;
    if (same) begin
      if ((run_inc == RunLimit) || pix_i.final_pixel) begin
        burst_o.bytes[0] = {TagRun, run_i};
        burst_o.cnt      = CntW'(1);
      end else begin
        run_o = run_inc;
      end
    end else begin
      idx_we_o = !idx_hit_i;
      if (pend) begin
        burst_o.bytes[0]   = {TagRun, run_i - RunW'(1)};
        burst_o.bytes[4:1] = body;
        burst_o.cnt        = CntW'(body_cnt) + CntW'(1);
      end else begin
        burst_o.bytes[3:0] = body;
        burst_o.cnt        = CntW'(body_cnt);
      end
    end
  end

endmodule

>>> hdl/qoi_obuf.sv
// Output register that sends the chunk bytes of one pixel, one per cycle while chunk_ready_i is high.
module qoi_obuf
  import qoi_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  burst_t burst_i,
  output logic   free_o,
  output chunk_t chunk_o,
  output logic   chunk_valid_o,
  input  logic   chunk_ready_i
);

  logic [MaxBytes-1:0][7:0] bytes_q, bytes_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     pop;

  assign pop    = (cnt_q != '0) && chunk_ready_i;
  assign free_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && chunk_ready_i);

  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      bytes_d = burst_i.bytes;
      cnt_d   = burst_i.cnt;
    end else if (pop) begin
      bytes_d = {8'h00, bytes_q[MaxBytes-1:1]};
      cnt_d   = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign chunk_valid_o     = (cnt_q != '0);
  assign chunk_o.out_byte  = bytes_q[0];
  assign chunk_o.last_byte = (cnt_q == CntW'(1));

endmodule

>>> hdl/qoi_rgb_pixel_encoder_unit.sv
// Flow: an accepted pixel request enters the evaluation stage; when it commits, its chunk
//   bytes are loaded into the output register, which drives chunk_o. A pixel waits in the
//   evaluation stage while the output register has no room for its bytes.
// Throughput: one pixel per cycle while each pixel gives at most one byte and chunk_ready_i
//   is high; a pixel that gives n bytes holds the output register until all n are sent.
// Reset: rst_ni is asynchronous and active low; it clears the previous pixel, the run count
//   and all 64 index valid bits at once, so no clearing pass follows reset.
module qoi_rgb_pixel_encoder_unit
  import qoi_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  pix_t   pix_i,
  input  logic   pix_valid_i,
  output logic   pix_ready_o,
  output chunk_t chunk_o,
  output logic   chunk_valid_o,
  input  logic   chunk_ready_i
);

  // The colour index keeps its RGB values in a RAM and its valid bits in flip-flops.
  // A pixel reads its slot when its request is accepted. The evaluation stage writes
  // the slot of a missed pixel in the same cycle, so a read issued at that edge would
  // return the old entry; such a collision is caught at accept time and the written
  // colour is forwarded into the evaluation stage instead.

  logic                 accept;
  logic                 commit;
  logic [9:0]           hash_sum;
  logic [SlotW-1:0]     slot_in;

  logic                 s1_valid_q, s1_valid_d;
  pix_t                 s1_pix_q;
  logic [SlotW-1:0]     s1_slot_q;
  logic                 fwd_hit_q;
  logic [RgbW-1:0]      fwd_rgb_q;

  logic [RgbW-1:0]      prev_q;
  logic [RunW-1:0]      run_q;
  logic [IdxDepth-1:0]  idx_valid_q;

  logic [RgbW-1:0]      ram_rdata;
  logic [RgbW-1:0]      idx_rgb;
  logic                 idx_hit;
  logic [RgbW-1:0]      s1_rgb;

  burst_t               burst;
  logic [RunW-1:0]      run_next;
  logic                 idx_we;
  logic                 wr_en;
  logic                 obuf_free;

  // Slot hash (3r + 5g + 7b + 11a) mod 64 with alpha fixed at 255.
  assign hash_sum = (10'(pix_i.red) * 10'd3) + (10'(pix_i.green) * 10'd5)
                  + (10'(pix_i.blue) * 10'd7);
  assign slot_in  = hash_sum[SlotW-1:0] + IdxBias;

  // A pixel leaves the evaluation stage once its bytes fit into the output register;
  // a pixel that only extends a run leaves at once.
  assign commit      = s1_valid_q && ((burst.cnt == '0) || obuf_free);
  assign pix_ready_o = !s1_valid_q || commit;
  assign accept      = pix_valid_i && pix_ready_o;
  assign wr_en       = commit && idx_we;

  assign s1_rgb  = {s1_pix_q.red, s1_pix_q.green, s1_pix_q.blue};
  assign idx_rgb = fwd_hit_q ? fwd_rgb_q : ram_rdata;
  assign idx_hit = idx_valid_q[s1_slot_q] && (idx_rgb == s1_rgb);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (commit) begin
      s1_valid_d = 1'b0;
    end
  end

  qoi_ram #(
    .Width (RgbW),
    .Depth (IdxDepth)
  ) u_idx_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_slot_q),
    .wdata_i (s1_rgb),
    .re_i    (accept),
    .raddr_i (slot_in),
    .rdata_o (ram_rdata)
  );

  qoi_chunk u_chunk (
    .pix_i     (s1_pix_q),
    .prev_i    (prev_q),
    .run_i     (run_q),
    .slot_i    (s1_slot_q),
    .idx_hit_i (idx_hit),
    .burst_o   (burst),
    .run_o     (run_next),
    .idx_we_o  (idx_we)
  );

  qoi_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (commit && (burst.cnt != '0)),
    .burst_i       (burst),
    .free_o        (obuf_free),
    .chunk_o       (chunk_o),
    .chunk_valid_o (chunk_valid_o),
    .chunk_ready_i (chunk_ready_i)
  );

  // Control and encoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      prev_q      <= '0;
      run_q       <= '0;
      idx_valid_q <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (commit) begin
        prev_q <= s1_rgb;
        run_q  <= run_next;
      end
      if (wr_en) begin
        idx_valid_q[s1_slot_q] <= 1'b1;
      end
    end
  end

  // Evaluation stage payload and the forwarding path for a same-edge write.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pix_i;
      s1_slot_q <= slot_in;
      fwd_hit_q <= wr_en && (s1_slot_q == slot_in);
      fwd_rgb_q <= s1_rgb;
    end
  end

endmodule

>>> hdl/qoi_checker.sv
// Port-level checks for the QOI RGB pixel encoder, bound to its top level.
module qoi_checker
  import qoi_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  input pix_t   pix_i,
  input logic   pix_valid_i,
  input logic   pix_ready_o,
  input chunk_t chunk_o,
  input logic   chunk_valid_o,
  input logic   chunk_ready_i
);

  // A stalled output request keeps its valid and its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_valid_o && !chunk_ready_i |=> chunk_valid_o && $stable(chunk_o))
    else $error("output request dropped or changed while stalled");

  // The bytes of one pixel go out back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_valid_o && chunk_ready_i && !chunk_o.last_byte |=> chunk_valid_o)
    else $error("gap inside the chunk bytes of one pixel");

  // With the output empty, the encoder always takes a new pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !chunk_valid_o |-> pix_ready_o)
    else $error("pixel input stalled while output is empty");

endmodule

bind qoi_rgb_pixel_encoder_unit qoi_checker u_qoi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pix_i         (pix_i),
  .pix_valid_i   (pix_valid_i),
  .pix_ready_o   (pix_ready_o),
  .chunk_o       (chunk_o),
  .chunk_valid_o (chunk_valid_o),
  .chunk_ready_i (chunk_ready_i)
);

>>> sim/tb_qoi_rgb_pixel_encoder_unit.sv
// Testbench for the QOI RGB pixel encoder: directed pixel table, then random pixel streams.
module tb_qoi_rgb_pixel_encoder_unit
  import qoi_pkg::*;
;

  localparam int unsigned NDir        = 22;
  localparam int unsigned RandPixels  = 250;
  localparam int unsigned CalmTail    = 40;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned CycleLimit  = 400000;

  // One directed row: the pixel, and where the chunk bytes are obvious, the bytes
  // themselves with the first byte in the top octet.
  typedef struct packed {
    pix_t        px;
    logic        typed;
    logic [2:0]  nbytes;
    logic [39:0] bytes;
  } stim_row_t;

  logic   clk_i;
  logic   rst_ni        = 1'b0;
  pix_t   pix_i         = '0;
  logic   pix_valid_i   = 1'b0;
  logic   pix_ready_o;
  chunk_t chunk_o;
  logic   chunk_valid_o;
  logic   chunk_ready_i = 1'b0;

  qoi_rgb_pixel_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix_i),
    .pix_valid_i   (pix_valid_i),
    .pix_ready_o   (pix_ready_o),
    .chunk_o       (chunk_o),
    .chunk_valid_o (chunk_valid_o),
    .chunk_ready_i (chunk_ready_i)
  );

  // Directed rows start from the reset state: previous pixel black, index empty.
  stim_row_t dir_tbl [NDir] = '{
    {8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd0, 40'h00_00_00_00_00}, // black repeats reset pixel
    {8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 3'd1, 40'hC1_00_00_00_00}, // final flushes run of two
    {8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 3'd1, 40'h55_00_00_00_00}, // wraps to delta -1
    {8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd1, 40'h7F_00_00_00_00}, // wraps to delta +1
    {8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 3'd1, 40'h26_00_00_00_00}, // white found in index
    {8'hFF, 8'h00, 8'h80, 1'b0, 1'b1, 3'd4, 40'hFE_FF_00_80_00}, // full RGB chunk
    {8'hFE, 8'h01, 8'h7F, 1'b0, 1'b0, 3'd0, 40'h0},
    {8'hFC, 8'h03, 8'h81, 1'b0, 1'b0, 3'd0, 40'h0},              // +2 is out of range
    {8'hFA, 8'h01, 8'h7F, 1'b0, 1'b0, 3'd0, 40'h0},              // -2 on every channel
    {8'hFA, 8'h01, 8'h7F, 1'b0, 1'b1, 3'd0, 40'h00_00_00_00_00},
    {8'hFA, 8'h01, 8'h7F, 1'b1, 1'b1, 3'd1, 40'hC1_00_00_00_00},
    {8'hFA, 8'h01, 8'h7F, 1'b0, 1'b0, 3'd0, 40'h0},              // next image, no reset
    {8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 40'h0},              // run flush then index
    {8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 3'd0, 40'h0},
    {8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 3'd0, 40'h0},
    {8'h80, 8'h80, 8'h80, 1'b0, 1'b0, 3'd0, 40'h0},              // flush plus RGB, slot clash
    {8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 40'h0},              // evicted slot misses
    {8'h01, 8'h01, 8'h00, 1'b0, 1'b0, 3'd0, 40'h0},
    {8'h7F, 8'h80, 8'hFF, 1'b1, 1'b0, 3'd0, 40'h0},              // final with no run
    {8'h7F, 8'h80, 8'hFF, 1'b0, 1'b0, 3'd0, 40'h0},
    {8'hFF, 8'h00, 8'h80, 1'b1, 1'b0, 3'd0, 40'h0},
    {8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 3'd0, 40'h0}
  };

  // Encoder state as the predictor sees it.
  logic [23:0]  last_rgb;
  logic [5:0]   run_len;
  logic [24:0]  color_slots [IdxDepth];

  chunk_t       chunk_due_q [$];
  logic [23:0]  recent_rgb [8];
  logic [2:0]   recent_wr;

  logic         calm  = 1'b0;
  logic         quiet = 1'b0;
  int           stall_left;
  int           n_errors, n_cycles, n_bytes, n_pixels, n_rand;
  int           n_run, n_index, n_diff, n_rgb;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic burst_t with_byte(burst_t b, logic [7:0] v);
    b.bytes[b.cnt] = v;
    b.cnt = b.cnt + 1'b1;
    return b;
  endfunction

  // Predicts the chunk bytes of one pixel and advances the predicted state.
  task automatic encode_pixel(input pix_t p, output burst_t due);
    logic [23:0]      rgb;
    logic [SlotW-1:0] slot;
    logic [7:0]       dr, dg, db;
    rgb = {p.red, p.green, p.blue};
    due = '0;
    if (rgb == last_rgb) begin
      run_len = run_len + 1'b1;
      if (run_len == RunLimit || p.final_pixel) begin
        due = with_byte(due, {TagRun, 6'(run_len - 1'b1)});
        run_len = '0;
        n_run++;
      end
    end else begin
      // A pending run always goes out ahead of the new color.
      if (run_len != 0) begin
        due = with_byte(due, {TagRun, 6'(run_len - 1'b1)});
        run_len = '0;
        n_run++;
      end
      slot = SlotW'(3 * p.red + 5 * p.green + 7 * p.blue) + IdxBias;
      if (color_slots[slot] == {1'b1, rgb}) begin
        due = with_byte(due, {TagIndex, slot});
        n_index++;
      end else begin
        color_slots[slot] = {1'b1, rgb};
        // Biased deltas: anything in 0..3 means the true delta lies in -2..1.
        dr = p.red   - last_rgb[23:16] + 8'd2;
        dg = p.green - last_rgb[15:8]  + 8'd2;
        db = p.blue  - last_rgb[7:0]   + 8'd2;
        if (dr <= 8'd3 && dg <= 8'd3 && db <= 8'd3) begin
          due = with_byte(due, {TagDiff, dr[1:0], dg[1:0], db[1:0]});
          n_diff++;
        end else begin
          due = with_byte(due, TagRgb);
          due = with_byte(due, p.red);
          due = with_byte(due, p.green);
          due = with_byte(due, p.blue);
          n_rgb++;
        end
      end
      last_rgb = rgb;
    end
  endtask

  task automatic queue_burst(input burst_t due);
    for (int k = 0; k < int'(due.cnt); k++)
      chunk_due_q.push_back({due.bytes[k], k == int'(due.cnt) - 1});
  endtask

  // Offers one pixel request, holds it until accepted, then predicts its chunk bytes.
  task automatic send_pixel(input pix_t p, output burst_t due);
    int gap;
    gap = 0;
    if (!quiet && !calm && $urandom_range(0, 5) == 0)
      gap = $urandom_range(1, 19);
    if (gap > 0) begin
      pix_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_i       <= p;
    pix_valid_i <= 1'b1;
    do @(posedge clk_i); while (!pix_ready_o);
    encode_pixel(p, due);
    n_pixels++;
  endtask

  task automatic feed(input logic [23:0] rgb, input logic fin);
    burst_t due;
    send_pixel({rgb, fin}, due);
    queue_burst(due);
    recent_rgb[recent_wr] = rgb;
    recent_wr = recent_wr + 1'b1;
    n_rand++;
  endtask

  // Chunk side: compare each accepted byte with the oldest prediction, and stall at random.
  always @(posedge clk_i) begin : chunk_check
    chunk_t want;
    if (rst_ni && chunk_valid_o && chunk_ready_i) begin
      n_bytes++;
      if (chunk_due_q.size() == 0) begin
        $display("%0t unexpected chunk byte: expected none, actual %02h last %0b",
                 $time, chunk_o.out_byte, chunk_o.last_byte);
        n_errors++;
      end else begin
        want = chunk_due_q.pop_front();
        if (chunk_o.out_byte !== want.out_byte) begin
          $display("%0t out_byte: expected %02h, actual %02h",
                   $time, want.out_byte, chunk_o.out_byte);
          n_errors++;
        end
        if (chunk_o.last_byte !== want.last_byte) begin
          $display("%0t last_byte: expected %0b, actual %0b",
                   $time, want.last_byte, chunk_o.last_byte);
          n_errors++;
        end
      end
    end
    if (quiet || calm) begin
      chunk_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      chunk_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 18);
      chunk_ready_i <= 1'b0;
    end else begin
      chunk_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("%0t timeout with %0d chunk bytes still due", $time, chunk_due_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    burst_t      due;
    stim_row_t   row;
    logic [23:0] rgb;
    logic [7:0]  dr, dg, db;
    logic [7:0]  edge_vals [6];
    logic        paused;
    int          len, mode, ch;
    edge_vals = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    paused    = 1'b0;
    last_rgb  = '0;
    run_len   = '0;
    recent_wr = '0;
    for (int i = 0; i < IdxDepth; i++) color_slots[i] = '0;
    for (int i = 0; i < 8; i++) recent_rgb[i] = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. Typed rows are checked against their own bytes, the rest
    // against the predictor, which sees every row so its state stays in step.
    for (int i = 0; i < NDir; i++) begin
      row = dir_tbl[i];
      send_pixel(row.px, due);
      if (row.typed) begin
        due = '0;
        for (int k = 0; k < int'(row.nbytes); k++)
          due = with_byte(due, row.bytes[39 - 8 * k -: 8]);
      end
      queue_burst(due);
    end

    // Random streams: runs, small steps, revisits of recent colors, edge values, and noise.
    while (n_rand < RandPixels) begin
      if (!paused && n_rand >= RandPixels / 2) begin
        // Let the encoder drain completely before going on.
        paused = 1'b1;
        pix_valid_i <= 1'b0;
        do @(posedge clk_i); while (chunk_due_q.size() != 0);
      end
      if (n_rand >= RandPixels - CalmTail) quiet <= 1'b1;
      calm <= ($urandom_range(0, 3) == 0);
      mode = (n_rand == 0) ? 0 : $urandom_range(0, 9);
      case (mode)
        0, 1: begin
          // The first stream is a long run, so the run limit can be reached.
          len = (n_rand == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(60, 126)
                                                           : $urandom_range(1, 5);
          for (int j = 0; j < len; j++)
            feed(last_rgb, j == len - 1 && $urandom_range(0, 3) == 0);
        end
        2, 3, 9: begin
          len = (mode == 9) ? $urandom_range(3, 8) : 1;
          for (int j = 0; j < len; j++) begin
            dr = 8'($urandom_range(0, 3)) - 8'd2;
            dg = 8'($urandom_range(0, 3)) - 8'd2;
            db = 8'($urandom_range(0, 3)) - 8'd2;
            if ($urandom_range(0, 3) == 0) begin
              // Push one channel just outside the diff range.
              ch = $urandom_range(0, 2);
              rgb = $urandom_range(0, 1) ? {3{8'd2}} : {3{8'hFD}};
              if (ch == 0) dr = rgb[7:0];
              else if (ch == 1) dg = rgb[7:0];
              else db = rgb[7:0];
            end
            rgb = {last_rgb[23:16] + dr, last_rgb[15:8] + dg, last_rgb[7:0] + db};
            feed(rgb, $urandom_range(0, 11) == 0);
          end
        end
        4, 5: feed(recent_rgb[$urandom_range(0, 7)], $urandom_range(0, 11) == 0);
        6, 7: feed(24'($urandom), $urandom_range(0, 11) == 0);
        default: feed({edge_vals[$urandom_range(0, 5)], edge_vals[$urandom_range(0, 5)],
                       edge_vals[$urandom_range(0, 5)]}, $urandom_range(0, 11) == 0);
      endcase
    end

    pix_valid_i <= 1'b0;
    while (chunk_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d pixels and %0d checked chunk bytes.", n_pixels, n_bytes);
    $display("Chunks predicted: %0d run, %0d index, %0d diff, %0d full RGB.",
             n_run, n_index, n_diff, n_rgb);
    if (n_errors == 0 && chunk_due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/qoi_pkg.sv
hdl/qoi_ram.sv
hdl/qoi_chunk.sv
hdl/qoi_obuf.sv
hdl/qoi_rgb_pixel_encoder_unit.sv
hdl/qoi_checker.sv
sim/tb_qoi_rgb_pixel_encoder_unit.sv
